// ===== rtl/pid_speed_regulator_with_startup_assert.svh =====
// Assertion macros for the speed regulator checker
`ifndef PID_SPEED_REGULATOR_WITH_STARTUP_ASSERT_SVH
`define PID_SPEED_REGULATOR_WITH_STARTUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define PSR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pidsr checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pidsr checker: next-cycle property failed");

`endif

// ===== rtl/pidsr_pkg.sv =====
`default_nettype none
package pidsr_pkg;

  // Port field widths
  localparam int CMD_W      = 2;
  localparam int SPEED_W    = 16;
  localparam int DUTY_W     = 15;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN  = 3'd6;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP  = 24'd65536;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG = 24'd6554;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV = 24'd0;
  localparam logic [SPEED_W-1:0] RST_TARGET     = 16'd3000;
  localparam logic [SPEED_W-1:0] RST_DIVISOR    = 16'd60;
  localparam logic [DUTY_W-1:0]  RST_DRIVE_MAX  = 15'd25600;
  localparam logic [DUTY_W-1:0]  RST_DRIVE_MIN  = 15'd0;

  // Setpoint window and start-up drive
  localparam logic [SPEED_W-1:0] MIN_SETPOINT = 16'd500;
  localparam logic [SPEED_W-1:0] MAX_SETPOINT = 16'd6000;
  localparam logic [DUTY_W-1:0]  FULL_DRIVE   = 15'd25600;

  // Datapath widths
  localparam int ERR_W      = 34;
  localparam int INTEG_W    = 48;
  localparam int SUM_W      = 63;
  localparam int DRIVE_FRAC = 24;
  localparam int ERR_FRAC   = 16;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  // Shared divider: dividend covers duty << 24, divisor covers a gain
  localparam int DIV_N_W   = 40;
  localparam int DIV_D_W   = 24;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Shared shift-add multiplier
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam logic [MUL_P_W-1:0] PROD_LIMIT = {{(MUL_P_W-61){1'b0}}, 1'b1, 60'd0};

endpackage
`default_nettype wire

// ===== rtl/pid_speed_regulator_with_startup.sv =====
// Path to out_valid: stop, spare, idle and full-drive items go straight to the result; a start
//   command takes one pass of the 40-step shared divider, a regulated sample a divider pass and
//   three 24-step shift-add multiplier passes, and the sample that ends start-up a preload
//   divider pass before those. One item at a time: the next word is taken once the result is out.
// Reset (synchronous, rst_n low): registers to defaults, regulation off, start-up on,
//   integrator and last error cleared, no word pending.
`default_nettype none
module pid_speed_regulator_with_startup (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [pidsr_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [pidsr_pkg::SPEED_W-1:0]    in_speed,
  input  wire logic [pidsr_pkg::DUTY_W-1:0]     in_pwm_duty,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [pidsr_pkg::DUTY_W-1:0]          out_drive,
  output logic                                  out_running,
  output logic                                  out_starting,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pidsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pidsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_EDIV, ST_INTEG, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_CLAMP, ST_DONE
  } state_t;

  localparam int ERR_W   = pidsr_pkg::ERR_W;
  localparam int INTEG_W = pidsr_pkg::INTEG_W;
  localparam int SUM_W   = pidsr_pkg::SUM_W;
  localparam int SPEED_W = pidsr_pkg::SPEED_W;
  localparam int DUTY_W  = pidsr_pkg::DUTY_W;

  // Configuration registers
  logic [pidsr_pkg::GAIN_W-1:0] gp_r, gi_r, gd_r;
  logic [SPEED_W-1:0]           target_r, divisor_r;
  logic [DUTY_W-1:0]            dmax_r, dmin_r;

  // Sequencer and item state
  state_t                      state_r;
  logic [SPEED_W-1:0]          speed_r;
  logic [DUTY_W-1:0]           duty_r;
  logic                        regulate_r;
  logic                        enabled_r;
  logic                        startup_r;
  logic signed [INTEG_W-1:0]   integ_r;
  logic signed [ERR_W-1:0]     last_r;
  logic signed [ERR_W-1:0]     err_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic [DUTY_W-1:0]           drive_res_r;
  logic                        div_start_r;
  logic                        mul_start_r;
  logic                        out_valid_r;
  logic [DUTY_W-1:0]           out_drive_r;
  logic                        out_running_r;
  logic                        out_starting_r;

  // Shared unit connections
  logic [pidsr_pkg::DIV_N_W-1:0] div_dividend;
  logic [pidsr_pkg::DIV_D_W-1:0] div_divisor;
  logic                          div_done;
  logic [pidsr_pkg::DIV_N_W-1:0] div_quo;
  logic [pidsr_pkg::MUL_A_W-1:0] mul_mcand;
  logic [pidsr_pkg::MUL_B_W-1:0] mul_mplier;
  logic                          mul_neg;
  logic                          mul_done;
  logic [pidsr_pkg::MUL_P_W-1:0] mul_prod;

  // Datapath signals
  logic                          in_fire;
  logic [SPEED_W:0]              sp_diff;
  logic [SPEED_W:0]              sp_diff_neg;
  logic                          err_neg;
  logic [SPEED_W-1:0]            err_mag;
  logic [ERR_W-1:0]              quo_ext;
  logic signed [ERR_W-1:0]       err_val;
  logic signed [INTEG_W-1:0]     pre_val;
  logic [INTEG_W:0]              isum;
  logic signed [INTEG_W-1:0]     isat;
  logic [ERR_W-1:0]              err_abs;
  logic [ERR_W:0]                de;
  logic [ERR_W:0]                de_abs;
  logic [pidsr_pkg::MUL_P_W-1:0] prod_sat;
  logic [SUM_W-1:0]              term_mag;
  logic signed [SUM_W-1:0]       term;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic signed [SUM_W-1:0]       hi_lim;
  logic signed [SUM_W-1:0]       lo_lim;
  logic [DUTY_W-1:0]             clamp_val;

  // Handshakes
  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign cfg_ready = rst_n && (state_r == ST_IDLE);

  // Configuration writes; out-of-window setpoints and unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r      <= pidsr_pkg::RST_GAIN_PROP;
      gi_r      <= pidsr_pkg::RST_GAIN_INTEG;
      gd_r      <= pidsr_pkg::RST_GAIN_DERIV;
      target_r  <= pidsr_pkg::RST_TARGET;
      divisor_r <= pidsr_pkg::RST_DIVISOR;
      dmax_r    <= pidsr_pkg::RST_DRIVE_MAX;
      dmin_r    <= pidsr_pkg::RST_DRIVE_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pidsr_pkg::REG_GAIN_PROP:  gp_r <= cfg_data;
        pidsr_pkg::REG_GAIN_INTEG: gi_r <= cfg_data;
        pidsr_pkg::REG_GAIN_DERIV: gd_r <= cfg_data;
        pidsr_pkg::REG_TARGET: begin
          if (cfg_data[SPEED_W-1:0] >= pidsr_pkg::MIN_SETPOINT &&
              cfg_data[SPEED_W-1:0] <= pidsr_pkg::MAX_SETPOINT) begin
            target_r <= cfg_data[SPEED_W-1:0];
          end
        end
        pidsr_pkg::REG_DIVISOR:   divisor_r <= cfg_data[SPEED_W-1:0];
        pidsr_pkg::REG_DRIVE_MAX: dmax_r    <= cfg_data[DUTY_W-1:0];
        pidsr_pkg::REG_DRIVE_MIN: dmin_r    <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Speed error sign and magnitude
  always_comb begin
    sp_diff     = {1'b0, target_r} - {1'b0, speed_r};
    sp_diff_neg = -sp_diff;
    err_neg     = sp_diff[SPEED_W];
    err_mag     = err_neg ? sp_diff_neg[SPEED_W-1:0] : sp_diff[SPEED_W-1:0];
  end

  // Divider operands: integrator preload or scaled speed error
  always_comb begin
    if (state_r == ST_PRE) begin
      div_dividend = pidsr_pkg::DIV_N_W'({duty_r, {pidsr_pkg::DRIVE_FRAC{1'b0}}});
      div_divisor  = gi_r;
    end else begin
      div_dividend = pidsr_pkg::DIV_N_W'({err_mag, {pidsr_pkg::ERR_FRAC{1'b0}}});
      div_divisor  = (divisor_r == '0) ? pidsr_pkg::DIV_D_W'(1)
                                       : pidsr_pkg::DIV_D_W'(divisor_r);
    end
  end

  // Divider results: signed error, preload value with zero-gain case
  always_comb begin
    quo_ext = ERR_W'(div_quo[2*SPEED_W-1:0]);
    err_val = err_neg ? -$signed(quo_ext) : $signed(quo_ext);
    if (gi_r == '0) begin
      pre_val = (duty_r != '0) ? pidsr_pkg::INTEG_MAX : '0;
    end else begin
      pre_val = $signed(INTEG_W'(div_quo));
    end
  end

  // Integrator add with saturation
  always_comb begin
    isum = {integ_r[INTEG_W-1], integ_r}
         + {{(INTEG_W+1-ERR_W){err_r[ERR_W-1]}}, err_r};
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      isat = isum[INTEG_W] ? pidsr_pkg::INTEG_MIN : pidsr_pkg::INTEG_MAX;
    end else begin
      isat = $signed(isum[INTEG_W-1:0]);
    end
  end

  // Multiplier operands by term: magnitude, gain, sign
  always_comb begin
    err_abs = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    de      = {err_r[ERR_W-1], err_r} - {last_r[ERR_W-1], last_r};
    de_abs  = de[ERR_W] ? -de : de;
    case (state_r)
      ST_MUL_I: begin
        mul_mcand  = integ_r[INTEG_W-1] ? pidsr_pkg::MUL_A_W'(-integ_r)
                                        : pidsr_pkg::MUL_A_W'(integ_r);
        mul_mplier = gi_r;
        mul_neg    = integ_r[INTEG_W-1];
      end
      ST_MUL_D: begin
        mul_mcand  = pidsr_pkg::MUL_A_W'(de_abs);
        mul_mplier = gd_r;
        mul_neg    = de[ERR_W];
      end
      default: begin
        mul_mcand  = pidsr_pkg::MUL_A_W'(err_abs);
        mul_mplier = gp_r;
        mul_neg    = err_r[ERR_W-1];
      end
    endcase
  end

  // Limit the product, restore its sign, accumulate
  always_comb begin
    prod_sat = (mul_prod > pidsr_pkg::PROD_LIMIT) ? pidsr_pkg::PROD_LIMIT : mul_prod;
    term_mag = prod_sat[SUM_W-1:0];
    term     = mul_neg ? -$signed(term_mag) : $signed(term_mag);
    sum_nxt  = sum_r + term;
  end

  // Output clamp: upper test first
  always_comb begin
    hi_lim = $signed({{(SUM_W-DUTY_W-pidsr_pkg::DRIVE_FRAC){1'b0}}, dmax_r,
                      {pidsr_pkg::DRIVE_FRAC{1'b0}}});
    lo_lim = $signed({{(SUM_W-DUTY_W-pidsr_pkg::DRIVE_FRAC){1'b0}}, dmin_r,
                      {pidsr_pkg::DRIVE_FRAC{1'b0}}});
    if (sum_r > hi_lim) begin
      clamp_val = dmax_r;
    end else if (sum_r < lo_lim) begin
      clamp_val = dmin_r;
    end else begin
      clamp_val = sum_r[pidsr_pkg::DRIVE_FRAC +: DUTY_W];
    end
  end

  // Sequencer, regulator state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enabled_r   <= 1'b0;
      startup_r   <= 1'b1;
      integ_r     <= '0;
      last_r      <= '0;
      regulate_r  <= 1'b0;
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            speed_r <= in_speed;
            duty_r  <= in_pwm_duty;
            case (in_cmd)
              pidsr_pkg::CMD_START: begin
                regulate_r  <= 1'b0;
                div_start_r <= 1'b1;
                state_r     <= ST_PRE;
              end
              pidsr_pkg::CMD_STOP: begin
                enabled_r   <= 1'b0;
                drive_res_r <= '0;
                state_r     <= ST_DONE;
              end
              pidsr_pkg::CMD_SAMPLE: begin
                if (!enabled_r) begin
                  drive_res_r <= '0;
                  state_r     <= ST_DONE;
                end else if (startup_r && (in_speed < target_r)) begin
                  drive_res_r <= pidsr_pkg::FULL_DRIVE;
                  state_r     <= ST_DONE;
                end else if (startup_r) begin
                  startup_r   <= 1'b0;
                  regulate_r  <= 1'b1;
                  div_start_r <= 1'b1;
                  state_r     <= ST_PRE;
                end else begin
                  div_start_r <= 1'b1;
                  state_r     <= ST_EDIV;
                end
              end
              default: begin
                drive_res_r <= '0;
                state_r     <= ST_DONE;
              end
            endcase
          end
        end
        ST_PRE: begin
          if (div_done) begin
            integ_r <= pre_val;
            if (regulate_r) begin
              div_start_r <= 1'b1;
              state_r     <= ST_EDIV;
            end else begin
              enabled_r   <= 1'b1;
              drive_res_r <= '0;
              state_r     <= ST_DONE;
            end
          end
        end
        ST_EDIV: begin
          if (div_done) begin
            err_r   <= err_val;
            state_r <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          integ_r     <= isat;
          sum_r       <= '0;
          mul_start_r <= 1'b1;
          state_r     <= ST_MUL_P;
        end
        ST_MUL_P: begin
          if (mul_done) begin
            sum_r       <= sum_nxt;
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL_I;
          end
        end
        ST_MUL_I: begin
          if (mul_done) begin
            sum_r       <= sum_nxt;
            mul_start_r <= 1'b1;
            state_r     <= ST_MUL_D;
          end
        end
        ST_MUL_D: begin
          if (mul_done) begin
            sum_r   <= sum_nxt;
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          last_r      <= err_r;
          drive_res_r <= clamp_val;
          state_r     <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r    <= 1'b1;
            out_drive_r    <= drive_res_r;
            out_running_r  <= enabled_r;
            out_starting_r <= startup_r;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  pidsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  pidsr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign out_valid    = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_running  = out_running_r;
  assign out_starting = out_starting_r;

endmodule
`default_nettype wire

// ===== rtl/pidsr_div.sv =====
`default_nettype none
module pidsr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pidsr_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [pidsr_pkg::DIV_D_W-1:0] divisor,
  output logic                               done,
  output logic [pidsr_pkg::DIV_N_W-1:0]      quotient
);

  logic                              busy_r;
  logic                              done_r;
  logic [pidsr_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [pidsr_pkg::DIV_D_W-1:0]     rem_r;
  logic [pidsr_pkg::DIV_N_W-1:0]     quo_r;
  logic [pidsr_pkg::DIV_D_W-1:0]     dvsr_r;
  logic [pidsr_pkg::DIV_D_W:0]       trial;
  logic [pidsr_pkg::DIV_D_W:0]       trial_sub;
  logic                              fits;

  // Restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem_r, quo_r[pidsr_pkg::DIV_N_W-1]};
    fits      = trial >= {1'b0, dvsr_r};
    trial_sub = trial - {1'b0, dvsr_r};
  end

  // One quotient bit per cycle, dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvsr_r <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? trial_sub[pidsr_pkg::DIV_D_W-1:0] : trial[pidsr_pkg::DIV_D_W-1:0];
        quo_r <= {quo_r[pidsr_pkg::DIV_N_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pidsr_pkg::DIV_CNT_W'(pidsr_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/pidsr_mul.sv =====
`default_nettype none
module pidsr_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pidsr_pkg::MUL_A_W-1:0] mcand,
  input  wire logic [pidsr_pkg::MUL_B_W-1:0] mplier,
  output logic                               done,
  output logic [pidsr_pkg::MUL_P_W-1:0]      product
);

  logic                            busy_r;
  logic                            done_r;
  logic [pidsr_pkg::MUL_CNT_W-1:0] cnt_r;
  logic [pidsr_pkg::MUL_A_W-1:0]   mcand_r;
  logic [pidsr_pkg::MUL_P_W-1:0]   acc_r;
  logic [pidsr_pkg::MUL_A_W:0]     hi_sum;
  logic [pidsr_pkg::MUL_P_W-1:0]   acc_nxt;

  // Add the multiplicand into the upper half when the low bit is set, shift right
  always_comb begin
    hi_sum  = {1'b0, acc_r[pidsr_pkg::MUL_P_W-1:pidsr_pkg::MUL_B_W]}
            + (acc_r[0] ? {1'b0, mcand_r} : {(pidsr_pkg::MUL_A_W+1){1'b0}});
    acc_nxt = {hi_sum, acc_r[pidsr_pkg::MUL_B_W-1:1]};
  end

  // One multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        mcand_r <= mcand;
        acc_r   <= {{pidsr_pkg::MUL_A_W{1'b0}}, mplier};
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pidsr_pkg::MUL_CNT_W'(pidsr_pkg::MUL_B_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
`default_nettype wire

// ===== rtl/pidsr_checker.sv =====
`default_nettype none
`include "pid_speed_regulator_with_startup_assert.svh"
module pidsr_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [pidsr_pkg::DUTY_W-1:0] out_drive,
  input wire logic                         out_running,
  input wire logic                         out_starting
);

  logic seen_run_r;

  // Remember that a word has left start-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_run_r <= 1'b0;
    end else if (out_valid && !out_stall && !out_starting) begin
      seen_run_r <= 1'b1;
    end
  end

  // A stalled word holds
  `PSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_drive) && $stable(out_running) && $stable(out_starting))

  // The block is busy in the cycle after it takes a word
  `PSR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // Any drive implies regulation is on
  `PSR_ASSERT_SAME(a_drive_needs_run, clk, rst_n, out_valid && (out_drive != '0), out_running)

  // Start-up never returns once left
  `PSR_ASSERT_SAME(a_startup_once, clk, rst_n, out_valid && seen_run_r, !out_starting)

endmodule

bind pid_speed_regulator_with_startup pidsr_checker u_pidsr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_drive    (out_drive),
  .out_running  (out_running),
  .out_starting (out_starting)
);
`default_nettype wire

// ===== tb/pid_speed_regulator_with_startup_tb.sv =====
`timescale 1ns / 1ps
module pid_speed_regulator_with_startup_tb;
  import pidsr_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam longint      ACC_TOP     = 64'sd140737488355327;
  localparam longint      ACC_BOT     = -ACC_TOP - 64'sd1;
  localparam logic [63:0] PRODUCT_CAP = 64'd1 << 60;
  localparam int          PHASES      = 8;
  localparam int          PHASE_WORDS = 212;
  localparam int          PLAN_ROWS   = 45;

  typedef struct packed {
    logic [DUTY_W-1:0] drive;
    logic              running;
    logic              starting;
  } result_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CMD_W-1:0]      cmd;
    logic [SPEED_W-1:0]    speed;
    logic [DUTY_W-1:0]     duty;
    bit                    fixed;
    result_t               want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_cmd;
  logic [SPEED_W-1:0]    in_speed;
  logic [DUTY_W-1:0]     in_pwm_duty;
  logic                  out_valid;
  logic                  out_stall;
  logic [DUTY_W-1:0]     out_drive;
  logic                  out_running;
  logic                  out_starting;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Mirror of the regulator registers and state
  logic [GAIN_W-1:0]  gain_p     = RST_GAIN_PROP;
  logic [GAIN_W-1:0]  gain_i     = RST_GAIN_INTEG;
  logic [GAIN_W-1:0]  gain_d     = RST_GAIN_DERIV;
  logic [SPEED_W-1:0] setpoint   = RST_TARGET;
  logic [SPEED_W-1:0] err_div    = RST_DIVISOR;
  logic [DUTY_W-1:0]  clamp_hi   = RST_DRIVE_MAX;
  logic [DUTY_W-1:0]  clamp_lo   = RST_DRIVE_MIN;
  longint             integ_acc  = 0;
  longint             prev_err   = 0;
  bit                 regulating = 1'b0;
  bit                 in_boot    = 1'b1;

  result_t drive_due[$];
  int      mismatches = 0;
  bit      calm = 1'b0;

  // Directed words: typed expectations only where they are obvious
  row_t plan [PLAN_ROWS] = '{
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b1, '{15'd0, 1'b0, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd65535, 15'd25600, 1'b1,
      '{15'd0, 1'b0, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SPARE, 16'd1234, 15'd777, 1'b1, '{15'd0, 1'b0, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_STOP, 16'd0, 15'd0, 1'b1, '{15'd0, 1'b0, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_START, 16'd0, 15'd25600, 1'b1, '{15'd0, 1'b1, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b1,
      '{FULL_DRIVE, 1'b1, 1'b1}},
    '{ROW_REG, REG_DRIVE_MAX, 24'd1000, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd2999, 15'd100, 1'b1,
      '{FULL_DRIVE, 1'b1, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_STOP, 16'd0, 15'd0, 1'b1, '{15'd0, 1'b0, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd100, 15'd0, 1'b1, '{15'd0, 1'b0, 1'b1}},
    '{ROW_REG, REG_TARGET, 24'd499, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_TARGET, 24'd6001, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_TARGET, 24'd500, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_TARGET, 24'd6000, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_DRIVE_MAX, 24'd25600, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_SPARE, 24'hFFFFFF, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_START, 16'd0, 15'd12800, 1'b1, '{15'd0, 1'b1, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd5999, 15'd0, 1'b1,
      '{FULL_DRIVE, 1'b1, 1'b1}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd6000, 15'd12800, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd65535, 15'd0, 1'b1,
      '{15'd0, 1'b1, 1'b0}},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_DIVISOR, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b1, '{15'd25600, 1'b1, 1'b0}},
    '{ROW_REG, REG_DRIVE_MAX, 24'd10000, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_DRIVE_MIN, 24'd20000, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd6000, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd65535, 15'd0, 1'b1,
      '{15'd20000, 1'b1, 1'b0}},
    '{ROW_REG, REG_GAIN_INTEG, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_START, 16'd0, 15'd100, 1'b1, '{15'd0, 1'b1, 1'b0}},
    '{ROW_REG, REG_DRIVE_MAX, 24'd25600, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_DRIVE_MIN, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_GAIN_PROP, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b1, '{15'd0, 1'b1, 1'b0}},
    '{ROW_REG, REG_GAIN_INTEG, 24'hFFFFFF, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd6000, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_GAIN_INTEG, 24'd1, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd6000, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_GAIN_INTEG, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_START, 16'd0, 15'd0, 1'b1, '{15'd0, 1'b1, 1'b0}},
    '{ROW_REG, REG_GAIN_DERIV, 24'hFFFFFF, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_GAIN_PROP, 24'd65536, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_GAIN_INTEG, 24'd6554, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_REG, REG_DIVISOR, 24'd65535, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd65535, 15'd0, 1'b0, '0},
    '{ROW_WORD, REG_SPARE, 24'd0, CMD_SAMPLE, 16'd0, 15'd0, 1'b0, '0}
  };

  pid_speed_regulator_with_startup u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_speed     (in_speed),
    .in_pwm_duty  (in_pwm_duty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive    (out_drive),
    .out_running  (out_running),
    .out_starting (out_starting),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Pause length: mostly none or short, now and then long
  function int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Load the integrator from the present duty
  function automatic void preload_integrator(logic [DUTY_W-1:0] duty);
    logic [63:0] num;
    num = 64'(duty) << 24;
    if (gain_i == '0) integ_acc = (duty != '0) ? ACC_TOP : 64'sd0;
    else integ_acc = longint'(num / 64'(gain_i));
  endfunction

  // Advance the regulator by one word and return the drive it yields
  function automatic result_t regulator_step(logic [CMD_W-1:0] cmd, logic [SPEED_W-1:0] speed,
                                             logic [DUTY_W-1:0] duty);
    result_t     r;
    longint      e, s, dv, i_term, top_q32, bot_q32;
    logic [63:0] mag, prod;
    r.drive = '0;
    case (cmd)
      CMD_START: begin
        preload_integrator(duty);
        regulating = 1'b1;
      end
      CMD_STOP: regulating = 1'b0;
      CMD_SAMPLE: begin
        if (regulating) begin
          if (in_boot && speed < setpoint) begin
            r.drive = FULL_DRIVE;
          end else begin
            if (in_boot) begin
              in_boot = 1'b0;
              preload_integrator(duty);
            end
            dv = (err_div == '0) ? 64'sd1 : longint'(err_div);
            e = ((longint'(setpoint) - longint'(speed)) * 64'sd65536) / dv;
            integ_acc += e;
            if (integ_acc > ACC_TOP) integ_acc = ACC_TOP;
            if (integ_acc < ACC_BOT) integ_acc = ACC_BOT;
            // Integral product saturates in magnitude
            mag = (integ_acc < 0) ? 64'(-integ_acc) : 64'(integ_acc);
            if (gain_i != '0 && mag > PRODUCT_CAP / 64'(gain_i)) prod = PRODUCT_CAP;
            else prod = mag * 64'(gain_i);
            i_term = (integ_acc < 0) ? -longint'(prod) : longint'(prod);
            s = e * longint'(gain_p) + i_term + (e - prev_err) * longint'(gain_d);
            prev_err = e;
            // Upper clamp is tested first
            top_q32 = longint'(clamp_hi) * 64'sd16777216;
            bot_q32 = longint'(clamp_lo) * 64'sd16777216;
            if (s > top_q32) r.drive = clamp_hi;
            else if (s < bot_q32) r.drive = clamp_lo;
            else r.drive = DUTY_W'(s / 64'sd16777216);
          end
        end
      end
      default: ;
    endcase
    r.running  = regulating;
    r.starting = in_boot;
    return r;
  endfunction

  // Drop both valids and hold until every expected word has come back
  task automatic settle();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (drive_due.size() != 0);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GAIN_PROP:  gain_p = data;
      REG_GAIN_INTEG: gain_i = data;
      REG_GAIN_DERIV: gain_d = data;
      REG_TARGET: begin
        if (data[SPEED_W-1:0] >= MIN_SETPOINT && data[SPEED_W-1:0] <= MAX_SETPOINT)
          setpoint = data[SPEED_W-1:0];
      end
      REG_DIVISOR:    err_div  = data[SPEED_W-1:0];
      REG_DRIVE_MAX:  clamp_hi = data[DUTY_W-1:0];
      REG_DRIVE_MIN:  clamp_lo = data[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one input word and queue its expected drive once taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SPEED_W-1:0] speed,
                           input logic [DUTY_W-1:0] duty, input bit fixed, input result_t want);
    int      gap;
    result_t got;
    cfg_valid <= 1'b0;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_speed    <= speed;
    in_pwm_duty <= duty;
    do @(posedge clk); while (in_stall);
    got = regulator_step(cmd, speed, duty);
    drive_due.push_back(fixed ? want : got);
  endtask

  // Receiver back-pressure
  initial begin : rx_pressure
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      n = pause_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each returned word with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_due.size() == 0) begin
        $display("%0t: unexpected word drive=%0d running=%0b starting=%0b",
                 $time, out_drive, out_running, out_starting);
        mismatches++;
      end else begin
        want = drive_due.pop_front();
        if (out_drive !== want.drive) begin
          $display("%0t: drive expected %0d got %0d", $time, want.drive, out_drive);
          mismatches++;
        end
        if (out_running !== want.running) begin
          $display("%0t: running expected %0b got %0b", $time, want.running, out_running);
          mismatches++;
        end
        if (out_starting !== want.starting) begin
          $display("%0t: starting expected %0b got %0b", $time, want.starting, out_starting);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #60_000_000;
    $display("pid_speed_regulator_with_startup test failed");
    $finish;
  end

  initial begin : stimulus
    logic [GAIN_W-1:0]  kp_w, ki_w, kd_w;
    logic [SPEED_W-1:0] sp_w, dv_w, speed;
    logic [DUTY_W-1:0]  hi_w, lo_w, duty;
    logic [CMD_W-1:0]   cmd;
    int                 r, v;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_SAMPLE;
    in_speed    = '0;
    in_pwm_duty = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_GAIN_PROP;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: start-up, clamps, setpoint window, preload corners
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].cmd, plan[i].speed, plan[i].duty, plan[i].fixed, plan[i].want);
    end

    // Random part, one register setting per phase
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          kp_w = 24'hFFFFFF; ki_w = 24'hFFFFFF; kd_w = 24'hFFFFFF;
          dv_w = 16'd1; sp_w = MAX_SETPOINT; hi_w = 15'd25600; lo_w = 15'd0;
        end
        1: begin
          kp_w = '0; ki_w = '0; kd_w = '0;
          dv_w = 16'd65535; sp_w = MIN_SETPOINT; hi_w = 15'd0; lo_w = 15'd0;
        end
        2: begin
          kp_w = RST_GAIN_PROP; ki_w = RST_GAIN_INTEG; kd_w = RST_GAIN_DERIV;
          dv_w = RST_DIVISOR; sp_w = RST_TARGET; hi_w = RST_DRIVE_MAX; lo_w = RST_DRIVE_MIN;
        end
        default: begin
          kp_w = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 18));
          ki_w = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 18));
          kd_w = GAIN_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 18));
          dv_w = SPEED_W'($urandom_range(1, 65535) >> $urandom_range(0, 16));
          sp_w = SPEED_W'($urandom_range(MIN_SETPOINT, MAX_SETPOINT));
          hi_w = DUTY_W'($urandom_range(0, 25600));
          if ($urandom_range(0, 4) == 0) lo_w = DUTY_W'($urandom_range(0, 25600));
          else lo_w = DUTY_W'($urandom_range(0, hi_w));
        end
      endcase
      calm = (phase == 2);
      // Any setpoint first, often outside the window, then a legal one
      write_reg(REG_TARGET, CFG_DATA_W'($urandom_range(0, 65535)));
      write_reg(REG_TARGET, CFG_DATA_W'(sp_w));
      write_reg(REG_GAIN_PROP, kp_w);
      write_reg(REG_GAIN_INTEG, ki_w);
      write_reg(REG_GAIN_DERIV, kd_w);
      write_reg(REG_DIVISOR, CFG_DATA_W'(dv_w));
      write_reg(REG_DRIVE_MAX, CFG_DATA_W'(hi_w));
      write_reg(REG_DRIVE_MIN, CFG_DATA_W'(lo_w));
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));

      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Mostly samples while regulating; restart soon after a stop
        r = $urandom_range(0, 99);
        if (regulating) begin
          if (r < 92) cmd = CMD_SAMPLE;
          else if (r < 95) cmd = CMD_START;
          else if (r < 98) cmd = CMD_STOP;
          else cmd = CMD_SPARE;
        end else begin
          if (r < 55) cmd = CMD_START;
          else if (r < 90) cmd = CMD_SAMPLE;
          else if (r < 95) cmd = CMD_STOP;
          else cmd = CMD_SPARE;
        end
        // Speeds cluster round the setpoint, with full-range and extreme values
        r = $urandom_range(0, 99);
        if (r < 50) begin
          v = int'(setpoint) + int'($urandom_range(0, 400)) - 200;
          speed = SPEED_W'(v);
        end else if (r < 80) begin
          speed = SPEED_W'($urandom_range(0, 65535));
        end else if (r < 90) begin
          speed = $urandom_range(0, 1) ? 16'd65535 : 16'd0;
        end else begin
          speed = setpoint;
        end
        r = $urandom_range(0, 99);
        if (r < 10) duty = '0;
        else if (r < 20) duty = 15'd25600;
        else duty = DUTY_W'($urandom_range(0, 25600));
        // Hold the sender now and then until the block has drained
        if ($urandom_range(0, 99) == 0) settle();
        send_word(cmd, speed, duty, 1'b0, '0);
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("pid_speed_regulator_with_startup test passed");
    end else begin
      $display("pid_speed_regulator_with_startup test failed");
    end
    $finish;
  end

endmodule
